// ===== src/pmct_pkg.sv =====
// Shared types and constants for the PS/2 mouse cursor tracker.
package pmct_pkg;

  localparam int COORD_BITS_DEFAULT  = 12;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int RES_BITS   = 13;
  localparam int SHIFT_BITS = 2;
  localparam int INDEX_BITS = 2;

  localparam int X_MARGIN    = 35;
  localparam int Y_MARGIN    = 48;
  localparam int POS_X_RESET = 400;
  localparam int POS_Y_RESET = 300;
  localparam int SUB_FLOOR   = 2;

  localparam logic [RES_BITS-1:0]   WIDTH_RESET  = 13'd800;
  localparam logic [RES_BITS-1:0]   HEIGHT_RESET = 13'd600;
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET  = 2'd1;

  // First-byte bit positions
  localparam int SYNC_BIT   = 3;
  localparam int LEFT_BIT   = 0;
  localparam int RIGHT_BIT  = 1;
  localparam int MIDDLE_BIT = 2;
  localparam int XSIGN_BIT  = 4;
  localparam int YSIGN_BIT  = 5;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_SPEED_SHIFT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] dx;
    logic [7:0] dy;
  } packet_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== src/pmct_framer.sv =====
// Front end: assembles received bytes into three-byte packets.
module pmct_framer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rx_valid,
  output logic                     rx_stall,
  input  logic [7:0]               rx_byte,
  input  logic                     rx_error,
  input  pmct_pkg::queue_status_t  q_status,
  output logic                     push,
  output pmct_pkg::packet_t        pkt
);

  typedef enum logic [1:0] {
    WAIT_FIRST,
    WAIT_SECOND,
    WAIT_THIRD
  } frame_state_t;

  frame_state_t state;
  logic [7:0]   first_byte;
  logic [7:0]   second_byte;
  logic         accept;

  assign rx_stall = q_status.full;
  assign accept   = rx_valid && !rx_stall;
  assign push     = accept && !rx_error && (state == WAIT_THIRD);

  assign pkt.first = first_byte;
  assign pkt.dx    = second_byte;
  assign pkt.dy    = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= WAIT_FIRST;
      first_byte  <= '0;
      second_byte <= '0;
    end else if (accept) begin
      if (rx_error) begin
        state <= WAIT_FIRST;
      end else begin
        case (state)
          WAIT_SECOND: begin
            second_byte <= rx_byte;
            state       <= WAIT_THIRD;
          end
          WAIT_THIRD: begin
            state <= WAIT_FIRST;
          end
          default: begin
            // only a byte with the sync bit set opens a packet
            if (rx_byte[pmct_pkg::SYNC_BIT]) begin
              first_byte <= rx_byte;
              state      <= WAIT_SECOND;
            end else begin
              state <= WAIT_FIRST;
            end
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_push_third: assert property (@(posedge clk) disable iff (rst)
    push |-> (state == WAIT_THIRD) && accept)
    else $error("packet pushed outside third byte");
  a_error_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && rx_error |=> state == WAIT_FIRST)
    else $error("error byte did not restart framing");
`endif

endmodule

// ===== src/pmct_queue.sv =====
// Short packet queue between framer and cursor update.
module pmct_queue #(
  parameter int DEPTH = pmct_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  pmct_pkg::packet_t        wr_data,
  input  logic                     pop,
  output pmct_pkg::packet_t        rd_data,
  output pmct_pkg::queue_status_t  status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]   LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

  pmct_pkg::packet_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign rd_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

// ===== src/pmct_mover.sv =====
// Back end: applies packets to the cursor and holds the result register.
module pmct_mover #(
  parameter int COORD_BITS = pmct_pkg::COORD_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pmct_pkg::RES_BITS-1:0]    screen_width,
  input  logic [pmct_pkg::RES_BITS-1:0]    screen_height,
  input  logic [pmct_pkg::SHIFT_BITS-1:0]  speed_shift,
  input  pmct_pkg::packet_t                pkt,
  input  pmct_pkg::queue_status_t          q_status,
  output logic                             pop,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [COORD_BITS-1:0]            cursor_x,
  output logic [COORD_BITS-1:0]            cursor_y,
  output logic                             left_button,
  output logic                             middle_button,
  output logic                             right_button
);

  localparam int CW = COORD_BITS;
  localparam int WW = ((CW > pmct_pkg::RES_BITS) ? CW : pmct_pkg::RES_BITS) + 2;
  localparam logic [CW-1:0] COORD_MAX = '1;
  localparam logic [CW:0]   FLOOR     = (CW + 1)'(pmct_pkg::SUB_FLOOR);

  function automatic logic [7:0] magnitude(input logic [7:0] b);
    return b[7] ? (~b + 8'd1) : b;
  endfunction

  function automatic logic [CW-1:0] sat_limit(input logic [pmct_pkg::RES_BITS-1:0] res,
                                              input logic [WW-1:0] margin);
    logic signed [WW-1:0] diff;
    diff = $signed({{(WW - pmct_pkg::RES_BITS){1'b0}}, res}) - $signed(margin);
    if (diff < 0) begin
      return '0;
    end else if (diff > $signed({{(WW - CW){1'b0}}, COORD_MAX})) begin
      return COORD_MAX;
    end
    return diff[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] move_axis(input logic [CW-1:0] pos,
                                              input logic [7:0] step,
                                              input logic sub,
                                              input logic [CW-1:0] lim);
    logic [CW:0] v;
    logic [CW:0] pos_w;
    logic [CW:0] step_w;
    pos_w  = {1'b0, pos};
    step_w = (CW + 1)'(step);
    if (sub) begin
      if (step_w > pos_w) begin
        // would underflow: creep down by one, never below the floor
        v = (pos_w > FLOOR) ? pos_w - 1'b1 : pos_w;
      end else begin
        v = pos_w - step_w;
      end
    end else begin
      v = pos_w + step_w;
    end
    if (v > {1'b0, lim}) begin
      v = {1'b0, lim};
    end else if (v == '0) begin
      v = (CW + 1)'(1);
    end
    return v[CW-1:0];
  endfunction

  logic [CW-1:0] lim_x;
  logic [CW-1:0] lim_y;
  logic [7:0]    step_x;
  logic [7:0]    step_y;
  logic [CW-1:0] cursor_x_next;
  logic [CW-1:0] cursor_y_next;

  assign lim_x  = sat_limit(screen_width, WW'(pmct_pkg::X_MARGIN));
  assign lim_y  = sat_limit(screen_height, WW'(pmct_pkg::Y_MARGIN));
  assign step_x = magnitude(pkt.dx) >> speed_shift;
  assign step_y = magnitude(pkt.dy) >> speed_shift;

  assign cursor_x_next = move_axis(cursor_x, step_x, pkt.first[pmct_pkg::XSIGN_BIT], lim_x);
  assign cursor_y_next = move_axis(cursor_y, step_y, !pkt.first[pmct_pkg::YSIGN_BIT], lim_y);

  assign pop = !q_status.empty && (!res_valid || !res_stall);

  // cursor registers double as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x  <= CW'(pmct_pkg::POS_X_RESET);
      cursor_y  <= CW'(pmct_pkg::POS_Y_RESET);
      res_valid <= 1'b0;
    end else if (pop) begin
      cursor_x  <= cursor_x_next;
      cursor_y  <= cursor_y_next;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      left_button   <= pkt.first[pmct_pkg::LEFT_BIT];
      middle_button <= pkt.first[pmct_pkg::MIDDLE_BIT];
      right_button  <= pkt.first[pmct_pkg::RIGHT_BIT];
    end
  end

`ifndef ASSERT_OFF
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> !pop)
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== src/ps2_mouse_cursor_tracker_top.sv =====
// Top level of the PS/2 mouse cursor tracker.
// Takes one received mouse byte per cycle unless stalled (rx_valid/rx_stall)
// and frames three-byte packets; each packet moves the cursor and yields one
// result (cursor_x, cursor_y, buttons) on res_valid/res_stall via the packet
// queue and cursor registers. A framer feeds a QUEUE_DEPTH-entry packet queue
// that drains into the cursor update, which completes one packet per cycle
// unless stalled; input stalls only once the queue is full behind a stalled
// result. Registers are written through cfg_valid/cfg_index/cfg_data, always
// ready: 0 screen width, 1 screen height, 2 speed shift; index 3 is ignored.
module ps2_mouse_cursor_tracker_top #(
  parameter int COORD_BITS  = pmct_pkg::COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = pmct_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rx_valid,
  output logic                             rx_stall,
  input  logic [7:0]                       rx_byte,
  input  logic                             rx_error,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic [COORD_BITS-1:0]            cursor_x,
  output logic [COORD_BITS-1:0]            cursor_y,
  output logic                             left_button,
  output logic                             middle_button,
  output logic                             right_button,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmct_pkg::INDEX_BITS-1:0]  cfg_index,
  input  logic [pmct_pkg::RES_BITS-1:0]    cfg_data
);

  logic [pmct_pkg::RES_BITS-1:0]   screen_width;
  logic [pmct_pkg::RES_BITS-1:0]   screen_height;
  logic [pmct_pkg::SHIFT_BITS-1:0] speed_shift;

  pmct_pkg::packet_t       push_pkt;
  pmct_pkg::packet_t       head_pkt;
  pmct_pkg::queue_status_t q_status;
  logic                    push;
  logic                    pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= pmct_pkg::WIDTH_RESET;
      screen_height <= pmct_pkg::HEIGHT_RESET;
      speed_shift   <= pmct_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (pmct_pkg::cfg_reg_t'(cfg_index))
        pmct_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        pmct_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        pmct_pkg::REG_SPEED_SHIFT:   speed_shift   <= cfg_data[pmct_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  pmct_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .rx_error (rx_error),
    .q_status (q_status),
    .push     (push),
    .pkt      (push_pkt)
  );

  pmct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_pkt),
    .pop     (pop),
    .rd_data (head_pkt),
    .status  (q_status)
  );

  pmct_mover #(
    .COORD_BITS (COORD_BITS)
  ) u_mover (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .speed_shift   (speed_shift),
    .pkt           (head_pkt),
    .q_status      (q_status),
    .pop           (pop),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .left_button   (left_button),
    .middle_button (middle_button),
    .right_button  (right_button)
  );

endmodule

// ===== bench/tb_ps2_mouse_cursor_tracker_top.sv =====
// Self-checking bench for the PS/2 mouse cursor tracker: directed table, then random packets.
module tb_ps2_mouse_cursor_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = pmct_pkg::COORD_BITS_DEFAULT;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam logic [pmct_pkg::INDEX_BITS-1:0] REG_UNUSED = 2'd3;  // index 3 has no register
  localparam int NUM_ROWS   = 32;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_BYTES = 115;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 10;

  localparam pmct_pkg::cfg_reg_t SEL_WIDTH  = pmct_pkg::REG_SCREEN_WIDTH;
  localparam pmct_pkg::cfg_reg_t SEL_HEIGHT = pmct_pkg::REG_SCREEN_HEIGHT;
  localparam pmct_pkg::cfg_reg_t SEL_SHIFT  = pmct_pkg::REG_SPEED_SHIFT;

  typedef logic [pmct_pkg::RES_BITS-1:0] res_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  left;
    logic                  middle;
    logic                  right;
  } cursor_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_t;

  typedef struct packed {
    row_kind_t           kind;
    pmct_pkg::cfg_reg_t  sel;
    logic [12:0]         value;
    logic                err;
    logic                fixed;
    cursor_t             want;
  } stim_row_t;

  localparam cursor_t NO_CHECK = '0;

  // Reset config is 800x600, shift 1; cursor starts at 400,300.
  localparam stim_row_t PLAN [NUM_ROWS] = '{
    '{ROW_BYTE, SEL_WIDTH,  13'h0F,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h7F,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h7F,   1'b0, 1'b1, '{12'd463, 12'd237, 1'b1, 1'b1, 1'b1}},
    '{ROW_BYTE, SEL_WIDTH,  13'h38,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h80,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h80,   1'b0, 1'b1, '{12'd399, 12'd301, 1'b0, 1'b0, 1'b0}},
    // no sync bit while waiting, then an error while waiting
    '{ROW_BYTE, SEL_WIDTH,  13'h00,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'hF7,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h08,   1'b1, 1'b0, NO_CHECK},
    // error on third byte abandons the packet
    '{ROW_BYTE, SEL_WIDTH,  13'h09,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h10,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h55,   1'b1, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'hFF,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'hFF,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h01,   1'b0, 1'b1, '{12'd399, 12'd301, 1'b1, 1'b1, 1'b1}},
    // x limit 1, y limit 0
    '{ROW_CFG,  SEL_WIDTH,  13'd36,   1'b0, 1'b0, NO_CHECK},
    '{ROW_CFG,  SEL_HEIGHT, 13'd48,   1'b0, 1'b0, NO_CHECK},
    '{ROW_CFG,  SEL_SHIFT,  13'd0,    1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h08,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h01,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h00,   1'b0, 1'b1, '{12'd1, 12'd0, 1'b0, 1'b0, 1'b0}},
    // x limit 3, y limit saturates at the coordinate max
    '{ROW_CFG,  SEL_WIDTH,  13'd38,   1'b0, 1'b0, NO_CHECK},
    '{ROW_CFG,  SEL_HEIGHT, 13'h1FFF, 1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h08,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h7F,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h80,   1'b0, 1'b1, '{12'd3, 12'd1, 1'b0, 1'b0, 1'b0}},
    // oversized subtract: decrement above the floor, hold at it
    '{ROW_BYTE, SEL_WIDTH,  13'h18,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h80,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h00,   1'b0, 1'b1, '{12'd2, 12'd1, 1'b0, 1'b0, 1'b0}},
    '{ROW_BYTE, SEL_WIDTH,  13'h18,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h80,   1'b0, 1'b0, NO_CHECK},
    '{ROW_BYTE, SEL_WIDTH,  13'h00,   1'b0, 1'b1, '{12'd2, 12'd1, 1'b0, 1'b0, 1'b0}}
  };

  logic                            clk;
  logic                            rst;
  logic                            rx_valid;
  logic                            rx_stall;
  logic [7:0]                      rx_byte;
  logic                            rx_error;
  logic                            res_valid;
  logic                            res_stall;
  logic [COORD_BITS-1:0]           cursor_x;
  logic [COORD_BITS-1:0]           cursor_y;
  logic                            left_button;
  logic                            middle_button;
  logic                            right_button;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [pmct_pkg::INDEX_BITS-1:0] cfg_index;
  logic [pmct_pkg::RES_BITS-1:0]   cfg_data;

  // predictor state
  int          pkt_pos = 0;
  logic [7:0]  hdr = '0;
  logic [7:0]  dx_byte = '0;
  int          cur_x = pmct_pkg::POS_X_RESET;
  int          cur_y = pmct_pkg::POS_Y_RESET;
  int          width_q = int'(pmct_pkg::WIDTH_RESET);
  int          height_q = int'(pmct_pkg::HEIGHT_RESET);
  int          shift_q = int'(pmct_pkg::SHIFT_RESET);

  cursor_t     pending_cursor [$];
  int          mismatches = 0;
  int          burst_left = 0;
  bit          hold_req = 0;

  ps2_mouse_cursor_tracker_top #(.COORD_BITS(COORD_BITS)) DUT (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_valid),
    .rx_stall      (rx_stall),
    .rx_byte       (rx_byte),
    .rx_error      (rx_error),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .left_button   (left_button),
    .middle_button (middle_button),
    .right_button  (right_button),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int byte_mag(input logic [7:0] b);
    return b[7] ? 256 - int'(b) : int'(b);
  endfunction

  function automatic int axis_limit(input int res, input int margin);
    int lim;
    lim = res - margin;
    if (lim < 0) return 0;
    if (lim > COORD_MAX) return COORD_MAX;
    return lim;
  endfunction

  function automatic int step_axis(input int pos, input int step, input bit sub, input int lim);
    int v;
    v = pos;
    if (sub) begin
      if (step > pos) begin
        if (pos > pmct_pkg::SUB_FLOOR) v = pos - 1;
      end else begin
        v = pos - step;
      end
    end else begin
      v = pos + step;
    end
    if (v > lim) v = lim;
    else if (v < 1) v = 1;
    return v & COORD_MAX;
  endfunction

  // Frames one byte; returns 1 with the new cursor when it completes a packet.
  function automatic bit advance_packet(input logic [7:0] b, input logic e, output cursor_t r);
    int sx;
    int sy;
    r = '0;
    if (e) begin
      pkt_pos = 0;
      return 1'b0;
    end
    if (pkt_pos == 1) begin
      dx_byte = b;
      pkt_pos = 2;
      return 1'b0;
    end
    if (pkt_pos != 2) begin
      pkt_pos = 0;
      if (b[pmct_pkg::SYNC_BIT]) begin
        hdr = b;
        pkt_pos = 1;
      end
      return 1'b0;
    end
    pkt_pos = 0;
    sx = byte_mag(dx_byte) >> shift_q;
    sy = byte_mag(b) >> shift_q;
    cur_x = step_axis(cur_x, sx, hdr[pmct_pkg::XSIGN_BIT],
                      axis_limit(width_q, pmct_pkg::X_MARGIN));
    cur_y = step_axis(cur_y, sy, !hdr[pmct_pkg::YSIGN_BIT],
                      axis_limit(height_q, pmct_pkg::Y_MARGIN));
    r.x = cur_x[COORD_BITS-1:0];
    r.y = cur_y[COORD_BITS-1:0];
    r.left = hdr[pmct_pkg::LEFT_BIT];
    r.middle = hdr[pmct_pkg::MIDDLE_BIT];
    r.right = hdr[pmct_pkg::RIGHT_BIT];
    return 1'b1;
  endfunction

  function automatic logic [7:0] move_byte();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] header_byte(input drift_t drift);
    logic [7:0] h;
    h = 8'($urandom_range(0, 255));
    h[pmct_pkg::SYNC_BIT] = 1'b1;
    if (drift != DRIFT_NONE && $urandom_range(0, 3) != 0) begin
      h[pmct_pkg::XSIGN_BIT] = (drift == DRIFT_DOWN);
      h[pmct_pkg::YSIGN_BIT] = (drift == DRIFT_UP);
    end
    return h;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Sender works in bursts; valid stays up inside a burst.
  task automatic send_byte(input logic [7:0] b, input logic e, input bit fixed, input cursor_t want);
    int gap;
    cursor_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    rx_valid <= 1'b1;
    rx_byte  <= b;
    rx_error <= e;
    do @(posedge clk); while (rx_stall);
    if (advance_packet(b, e, r)) pending_cursor.push_back(fixed ? want : r);
  endtask

  task automatic settle_idle();
    rx_valid <= 1'b0;
    while (pending_cursor.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [pmct_pkg::INDEX_BITS-1:0] idx, input res_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pmct_pkg::REG_SCREEN_WIDTH:  width_q = int'(data);
      pmct_pkg::REG_SCREEN_HEIGHT: height_q = int'(data);
      pmct_pkg::REG_SPEED_SHIFT:   shift_q = int'(data[pmct_pkg::SHIFT_BITS-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_screen(input int w, input int h, input int s);
    settle_idle();
    write_reg(pmct_pkg::REG_SCREEN_WIDTH, res_t'(w));
    write_reg(pmct_pkg::REG_SCREEN_HEIGHT, res_t'(h));
    write_reg(pmct_pkg::REG_SPEED_SHIFT, res_t'(s));
    write_reg(REG_UNUSED, res_t'($urandom_range(0, 8191)));
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    cursor_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_cursor.size() == 0) begin
        log_mismatch($sformatf("result %0d,%0d with nothing expected", cursor_x, cursor_y));
      end else begin
        want = pending_cursor.pop_front();
        if (cursor_x !== want.x)
          log_mismatch($sformatf("cursor_x got %0d want %0d", cursor_x, want.x));
        if (cursor_y !== want.y)
          log_mismatch($sformatf("cursor_y got %0d want %0d", cursor_y, want.y));
        if (left_button !== want.left)
          log_mismatch($sformatf("left_button got %b want %b", left_button, want.left));
        if (middle_button !== want.middle)
          log_mismatch($sformatf("middle_button got %b want %b", middle_button, want.middle));
        if (right_button !== want.right)
          log_mismatch($sformatf("right_button got %b want %b", right_button, want.right));
      end
    end
  end

  // receiver stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int len;
    int k;
    bit hold_done;
    hold_done = 0;
    res_stall <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          res_stall <= 1'b1;
        end
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(5, 40);
      for (k = 0; k < len; k++) begin
        @(posedge clk);
        case (mode)
          0: res_stall <= 1'b0;
          1: res_stall <= 1'($urandom_range(0, 1));
          default: res_stall <= (k % 4 == 3);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t row;
    bit cfg_open;
    int i;
    int phase;
    int sent;
    int pick;
    int n;
    drift_t drift;
    rst       <= 1'b1;
    rx_valid  <= 1'b0;
    rx_byte   <= '0;
    rx_error  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    cfg_open = 0;
    for (i = 0; i < NUM_ROWS; i++) begin
      row = PLAN[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) settle_idle();
        write_reg(row.sel, row.value);
        cfg_open = 1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 0;
        end
        send_byte(row.value[7:0], row.err, row.fixed, row.want);
      end
    end

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drift = DRIFT_NONE;
      case (phase)
        0: program_screen(64, 64, 3);
        1: begin
          program_screen(4096, 4096, 0);
          drift = DRIFT_UP;
        end
        2: begin
          program_screen(8191, 8191, 0);
          drift = DRIFT_UP;
        end
        3: program_screen($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3));
        5: begin
          program_screen($urandom_range(64, 4096), $urandom_range(64, 4096), 0);
          drift = DRIFT_DOWN;
        end
        default: program_screen($urandom_range(64, 4096), $urandom_range(64, 4096),
                                $urandom_range(0, 3));
      endcase
      if (phase == 4) hold_req = 1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_byte(header_byte(drift), 1'b0, 1'b0, NO_CHECK);
          send_byte(move_byte(), 1'b0, 1'b0, NO_CHECK);
          send_byte(move_byte(), 1'b0, 1'b0, NO_CHECK);
          sent += 3;
        end else if (pick < 90) begin
          // packet cut short by an errored byte
          n = $urandom_range(0, 2);
          if (n > 0) send_byte(header_byte(drift), 1'b0, 1'b0, NO_CHECK);
          if (n > 1) send_byte(move_byte(), 1'b0, 1'b0, NO_CHECK);
          send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_CHECK);
          sent += n + 1;
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, NO_CHECK);
          sent += 1;
        end
      end
    end

    rx_valid <= 1'b0;
    while (pending_cursor.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
